// ----- rtl/core/kwp_pkg.sv -----
package kwp_pkg;

    localparam logic [7:0] FMT_MAX_LEN = 8'h3F;
    localparam int unsigned NUM_SLOTS = 3;

    localparam logic [1:0] KIND_HEADER   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
    localparam logic [1:0] KIND_CHECKSUM = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
        logic [7:0] pkt_length;
    } kwp_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] byte_kind;
        logic       last;
    } kwp_out_t;

    typedef struct packed {
        logic [7:0] value;
        logic [1:0] kind;
    } kwp_slot_t;

endpackage

// ----- rtl/core/kwp_message_framer_top.sv -----
// The first byte of an item appears on line in the cycle after the item is accepted.
// Throughput: one output byte per cycle while line_stall is low; an item yields 1 to 3 bytes and holds
// the output register until its last byte leaves, and the next item is taken in the cycle its last byte leaves.
// Items that yield no bytes are accepted and leave the output buffer empty.
// Reset (rst_n low, asynchronous): no message open, output buffer empty.
module kwp_message_framer_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  kwp_pkg::kwp_in_t  req,
    output logic            line_valid,
    input  logic            line_stall,
    output kwp_pkg::kwp_out_t line
);
    import kwp_pkg::*;

    // message state
    logic       open_reg, open_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] sum_reg,  sum_next;

    // output buffer: up to three bytes from one item
    kwp_slot_t  slot_reg [NUM_SLOTS];
    kwp_slot_t  slot_next [NUM_SLOTS];
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg, idx_next;

    logic       accept;
    logic       pop;
    logic       done;
    logic       active;
    logic       long_hdr;
    logic       cks;
    logic [7:0] base_left;
    logic [7:0] base_sum;
    logic [7:0] new_left;
    logic [7:0] new_sum;
    logic [1:0] n_res;

    assign line_valid = (cnt_reg != 2'd0);
    assign pop        = line_valid && !line_stall;
    assign done       = pop && (idx_reg == cnt_reg - 2'd1);
    assign req_stall  = line_valid && !done;
    assign accept     = req_valid && !req_stall;

    assign line.out_byte  = slot_reg[idx_reg].value;
    assign line.byte_kind = slot_reg[idx_reg].kind;
    assign line.last      = (idx_reg == cnt_reg - 2'd1);

    assign active    = req.start_req ? (req.pkt_length != 8'd0) : open_reg;
    assign long_hdr  = req.start_req && (req.pkt_length > FMT_MAX_LEN);
    assign base_left = req.start_req ? req.pkt_length : left_reg;
    assign base_sum  = req.start_req ? req.pkt_length : sum_reg;
    assign new_left  = base_left - 8'd1;
    assign new_sum   = base_sum + req.data_byte;
    assign cks       = (new_left == 8'd0);

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        n_res = 2'd0;
        if (req.start_req)
        begin
            if (long_hdr)
            begin
                slot_next[0] = '{value: 8'd0, kind: KIND_HEADER};
                slot_next[1] = '{value: req.pkt_length, kind: KIND_HEADER};
                n_res = 2'd2;
            end
            else
            begin
                slot_next[0] = '{value: req.pkt_length, kind: KIND_HEADER};
                n_res = 2'd1;
            end
        end
        slot_next[n_res] = '{value: req.data_byte, kind: KIND_PAYLOAD};
        n_res = n_res + 2'd1;
        // a long header implies length >= 64, so no checksum can follow here
        if (cks && !long_hdr)
        begin
            slot_next[n_res] = '{value: new_sum, kind: KIND_CHECKSUM};
            n_res = n_res + 2'd1;
        end
    end

    always_comb
    begin
        open_next = open_reg;
        left_next = left_reg;
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        if (accept && active)
        begin
            open_next = !cks;
            left_next = new_left;
            sum_next  = cks ? 8'd0 : new_sum;
        end
        priority if (accept)
        begin
            cnt_next = active ? n_res : 2'd0;
            idx_next = 2'd0;
        end
        else if (done)
        begin
            cnt_next = 2'd0;
            idx_next = 2'd0;
        end
        else if (pop)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            left_reg <= 8'd0;
            sum_reg  <= 8'd0;
            cnt_reg  <= 2'd0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            open_reg <= open_next;
            left_reg <= left_next;
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

endmodule

// ----- verif/kwp_frame_checker.sv -----
`timescale 1ns / 100ps

module kwp_frame_checker
    import kwp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_stall,
    input  kwp_in_t  req,
    input  logic     line_valid,
    input  logic     line_stall,
    input  kwp_out_t line,
    output int       fail_count,
    output int       pending
);

    kwp_out_t   line_bytes_q[$];
    logic       msg_open;
    logic [7:0] bytes_left;
    logic [7:0] frame_sum;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t kwp_frame_checker: %s got %0h want %0h", $time, what, got, want);
        fail_count++;
    endtask

    // Works out the line bytes one accepted item causes.
    task automatic frame_item(input kwp_in_t it);
        kwp_out_t outs [3];
        int       n;
        n = 0;
        if (it.start_req) begin
            if (it.pkt_length == 8'd0)
                return;
            if (it.pkt_length <= FMT_MAX_LEN) begin
                outs[n] = '{out_byte: it.pkt_length, byte_kind: KIND_HEADER, last: 1'b0};
                n++;
            end
            else begin
                outs[n] = '{out_byte: 8'd0, byte_kind: KIND_HEADER, last: 1'b0};
                n++;
                outs[n] = '{out_byte: it.pkt_length, byte_kind: KIND_HEADER, last: 1'b0};
                n++;
            end
            // a new start drops whatever message was open
            msg_open   = 1'b1;
            bytes_left = it.pkt_length;
            frame_sum  = it.pkt_length;
        end
        else if (!msg_open) begin
            return;
        end
        outs[n] = '{out_byte: it.data_byte, byte_kind: KIND_PAYLOAD, last: 1'b0};
        n++;
        frame_sum  = frame_sum + it.data_byte;
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) begin
            outs[n] = '{out_byte: frame_sum, byte_kind: KIND_CHECKSUM, last: 1'b0};
            n++;
            msg_open  = 1'b0;
            frame_sum = 8'd0;
        end
        outs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            line_bytes_q.push_back(outs[i]);
    endtask

    always @(posedge clk or negedge rst_n) begin
        kwp_out_t want;
        if (!rst_n) begin
            line_bytes_q.delete();
            msg_open   = 1'b0;
            bytes_left = 8'd0;
            frame_sum  = 8'd0;
            fail_count = 0;
            pending    = 0;
        end
        else begin
            if (req_valid && !req_stall)
                frame_item(req);
            if (line_valid && !line_stall) begin
                if (line_bytes_q.size() == 0) begin
                    report_mismatch("unexpected byte", line, 0);
                end
                else begin
                    want = line_bytes_q.pop_front();
                    if (line.out_byte !== want.out_byte)
                        report_mismatch("out_byte", line.out_byte, want.out_byte);
                    if (line.byte_kind !== want.byte_kind)
                        report_mismatch("byte_kind", line.byte_kind, want.byte_kind);
                    if (line.last !== want.last)
                        report_mismatch("last", line.last, want.last);
                end
            end
            pending = line_bytes_q.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import kwp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    kwp_in_t  req;
    logic     line_valid;
    logic     line_stall = 1'b0;
    kwp_out_t line;

    int fail_count;
    int pending;
    int idle_pct;
    int stall_pct;
    int quiet_cycles = 0;

    always #5 clk = ~clk;

    kwp_message_framer_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .line_valid (line_valid),
        .line_stall (line_stall),
        .line       (line)
    );

    kwp_frame_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .line_valid (line_valid),
        .line_stall (line_stall),
        .line       (line),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(negedge clk)
        line_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (line_valid && !line_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input logic [7:0] d, input logic s, input logic [7:0] n);
        while ($urandom_range(99) < idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{data_byte: d, start_req: s, pkt_length: n};
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
        @(negedge clk);
    endtask

    task automatic drain_line;
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic send_message(input logic [7:0] len, input int body);
        send_item(8'($urandom_range(255)), 1'b1, len);
        for (int i = 0; i < body; i++) begin
            // zero-length start in the middle must leave the message open
            if ($urandom_range(99) < 4)
                send_item(8'($urandom_range(255)), 1'b1, 8'd0);
            send_item(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)));
        end
    endtask

    task automatic run_random(input int target);
        int sent;
        int pick;
        int len;
        int body;
        sent = 0;
        while (sent < target) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                // dropped unless a message is still open
                send_item(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)));
                sent++;
            end
            else if (pick < 12) begin
                send_item(8'($urandom_range(255)), 1'b1, 8'd0);
                sent++;
            end
            else begin
                pick = $urandom_range(99);
                if (pick < 70)
                    len = $urandom_range(6, 1);
                else if (pick < 85)
                    len = $urandom_range(68, 60);
                else
                    len = $urandom_range(255, 1);
                if (len <= 8) begin
                    body = len - 1;
                    if (len >= 2 && $urandom_range(99) < 10)
                        body = $urandom_range(len - 2);
                end
                else begin
                    body = $urandom_range(3);
                end
                send_message(8'(len), body);
                sent += body + 1;
            end
        end
    endtask

    initial begin
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        idle_pct   = 0;
        stall_pct  = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: boundaries of length, stray bytes, restarts
        send_item(8'hFF, 1'b0, 8'h55);
        send_item(8'h00, 1'b1, 8'h00);
        send_item(8'hFF, 1'b1, 8'h01);
        send_item(8'h00, 1'b1, 8'h3F);
        send_item(8'h12, 1'b1, 8'h00);
        send_item(8'hA5, 1'b0, 8'hFF);
        send_item(8'h80, 1'b1, 8'h40);
        send_item(8'h5A, 1'b0, 8'h00);
        send_item(8'h7F, 1'b1, 8'hFF);
        send_item(8'h01, 1'b0, 8'h80);
        send_item(8'hAA, 1'b1, 8'h02);
        send_item(8'h55, 1'b0, 8'h01);
        send_item(8'h33, 1'b0, 8'h03);
        send_item(8'hFE, 1'b1, 8'h03);
        send_item(8'hFF, 1'b0, 8'hFE);
        send_item(8'hFF, 1'b0, 8'h7F);
        send_item(8'h00, 1'b1, 8'h3E);
        send_item(8'hC3, 1'b1, 8'h01);
        drain_line();

        // one complete message with the two-byte header
        send_message(8'd64, 63);
        drain_line();

        idle_pct = 0;  stall_pct = 0;
        run_random(32);
        drain_line();
        idle_pct = 54; stall_pct = 0;
        run_random(32);
        drain_line();
        idle_pct = 0;  stall_pct = 54;
        run_random(32);
        drain_line();
        idle_pct = 38; stall_pct = 38;
        run_random(32);
        drain_line();

        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
